FILE: hdl/seq_line_command_parser_assert.svh
// Assertion macros shared by the line command parser RTL.
// Depends on nothing; files that check their own logic include this header.
`ifndef SEQ_LINE_COMMAND_PARSER_ASSERT_SVH
`define SEQ_LINE_COMMAND_PARSER_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define SLCP_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define SLCP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SLCP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/slcp_pkg.sv
// Shared types, character codes and limits of the line command parser.
// No dependencies; the lexer, accounting and top modules import this package.
package slcp_pkg;

    // Line and mode limits.
    localparam int unsigned LINE_CAP = 64;
    localparam int unsigned MODE_MAX = 3;
    localparam int unsigned LEN_W    = $clog2(LINE_CAP);
    localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(LINE_CAP - 1);

    localparam logic [31:0] U32_ALL     = 32'hFFFF_FFFF;
    localparam logic [31:0] ACC_LIMIT   = U32_ALL / 32'd10;
    localparam logic [3:0]  DIGIT_LIMIT = 4'(U32_ALL % 32'd10);
    localparam logic [31:0] MODE_LIMIT  = 32'(MODE_MAX);
    localparam logic [7:0]  MODE_RESET  = 8'(MODE_MAX);

    localparam logic [31:0] PERIOD_MIN_RESET = 32'd10;
    localparam logic [31:0] PERIOD_MAX_RESET = 32'd1000;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_MIN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_MAX = CFG_IDX_W'(1);

    // Character codes.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DIG0  = 8'h30;
    localparam logic [7:0] CH_DIG9  = 8'h39;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_Z     = 8'h5A;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_AFTER_TAG,
        PH_PRE_NUM,
        PH_NUM,
        PH_TRAIL,
        PH_BAD
    } t_phase;

    typedef enum logic [2:0] {
        TAG_NONE,
        TAG_Z,
        TAG_P,
        TAG_S,
        TAG_B,
        TAG_N
    } t_tag;

    typedef enum logic [2:0] {
        EV_NONE,
        EV_BAD,
        EV_RESET,
        EV_PING,
        EV_MODE,
        EV_BAUD,
        EV_PERIOD
    } t_event;

    // Parse state of the line in progress, handed to the accounting logic.
    typedef struct packed {
        t_phase      phase;
        t_tag        tag;
        logic [31:0] accum;
        logic        overflow;
        logic        digit_seen;
        logic        too_long;
    } t_line;

    // One configuration register write.
    typedef struct packed {
        logic                 en;
        logic [CFG_IDX_W-1:0] index;
        logic [31:0]          data;
    } t_cfg_write;

    // One result as it leaves the block.
    typedef struct packed {
        t_event      event_code;
        logic [31:0] event_value;
        logic [7:0]  mode_now;
        logic [31:0] ping_count;
        logic [31:0] bad_count;
        logic [31:0] gap_count;
        logic [31:0] dup_count;
    } t_result;

    // Decode a tag letter.
    function automatic t_tag tag_of(input logic [7:0] c);
        t_tag t;
        case (c)
            CH_Z:    t = TAG_Z;
            CH_P:    t = TAG_P;
            CH_S:    t = TAG_S;
            CH_B:    t = TAG_B;
            CH_N:    t = TAG_N;
            default: t = TAG_NONE;
        endcase
        return t;
    endfunction

endpackage

FILE: hdl/slcp_if.sv
// Handshake channels of the line command parser: received bytes, results
// and configuration writes. Depends on slcp_pkg.

// Received byte channel.
interface slcp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// Result channel.
interface slcp_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_code;
    logic [31:0] event_value;
    logic [7:0]  mode_now;
    logic [31:0] ping_count;
    logic [31:0] bad_count;
    logic [31:0] gap_count;
    logic [31:0] dup_count;

    modport source (output valid, output event_code, output event_value, output mode_now,
                    output ping_count, output bad_count, output gap_count,
                    output dup_count, input ready);
    modport sink   (input valid, input event_code, input event_value, input mode_now,
                    input ping_count, input bad_count, input gap_count,
                    input dup_count, output ready);
endinterface

// Configuration write channel.
interface slcp_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [slcp_pkg::CFG_IDX_W-1:0] index;
    logic [31:0]                   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/slcp_lexer.sv
// Per-byte line lexer: tracks length, tag, number and phase of the current line.
// Depends on slcp_pkg.
module slcp_lexer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_byte,
    output slcp_pkg::t_line      o_line
);
    import slcp_pkg::*;

    logic [LEN_W-1:0] r_len, n_len;
    logic             r_text_ended, n_text_ended;
    t_line            r_line, n_line;

    logic        is_space;
    logic        is_digit;
    logic [3:0]  digit;
    logic        acc_over;
    logic [31:0] acc_x10;

    // Character classes and the next decimal accumulation.
    always_comb begin
        is_space = (i_byte == CH_SPACE);
        is_digit = (i_byte >= CH_DIG0) && (i_byte <= CH_DIG9);
        digit    = i_byte[3:0];
        acc_over = (r_line.accum > ACC_LIMIT) ||
                   ((r_line.accum == ACC_LIMIT) && (digit > DIGIT_LIMIT));
        acc_x10  = {r_line.accum[28:0], 3'b000} + {r_line.accum[30:0], 1'b0} +
                   {28'd0, digit};
    end

    // Line state update for one byte.
    always_comb begin
        n_len        = r_len;
        n_text_ended = r_text_ended;
        n_line       = r_line;
        if (i_step) begin
            if (i_byte == CH_NL) begin
                n_len        = '0;
                n_text_ended = 1'b0;
                n_line       = '{phase: PH_LEAD, tag: TAG_NONE, accum: 32'd0,
                                 overflow: 1'b0, digit_seen: 1'b0, too_long: 1'b0};
            end else if (i_byte != CH_CR) begin
                if (r_len < LEN_LAST) begin
                    n_len = r_len + 1'b1;
                    if (i_byte == CH_NUL) begin
                        n_text_ended = 1'b1;
                    end else if (!r_text_ended) begin
                        case (r_line.phase)
                            PH_LEAD: begin
                                if (!is_space) begin
                                    n_line.tag   = tag_of(i_byte);
                                    n_line.phase = (tag_of(i_byte) == TAG_NONE) ?
                                                   PH_BAD : PH_AFTER_TAG;
                                end
                            end
                            PH_AFTER_TAG: begin
                                if (!is_space) begin
                                    n_line.phase = PH_BAD;
                                end else begin
                                    n_line.phase = (r_line.tag == TAG_Z) ?
                                                   PH_TRAIL : PH_PRE_NUM;
                                end
                            end
                            PH_PRE_NUM, PH_NUM: begin
                                if (is_digit) begin
                                    if (acc_over) begin
                                        n_line.overflow = 1'b1;
                                        n_line.phase    = PH_BAD;
                                    end else begin
                                        n_line.accum      = acc_x10;
                                        n_line.digit_seen = 1'b1;
                                        n_line.phase      = PH_NUM;
                                    end
                                end else if (is_space && (r_line.phase == PH_NUM)) begin
                                    n_line.phase = PH_TRAIL;
                                end else if (!is_space) begin
                                    n_line.phase = PH_BAD;
                                end
                            end
                            PH_TRAIL: begin
                                if (!is_space) begin
                                    n_line.phase = PH_BAD;
                                end
                            end
                            default: begin
                                n_line.phase = r_line.phase;
                            end
                        endcase
                    end
                end else begin
                    n_line.too_long = 1'b1;
                end
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len        <= '0;
            r_text_ended <= 1'b0;
            r_line       <= '{phase: PH_LEAD, tag: TAG_NONE, accum: 32'd0,
                              overflow: 1'b0, digit_seen: 1'b0, too_long: 1'b0};
        end else begin
            r_len        <= n_len;
            r_text_ended <= n_text_ended;
            r_line       <= n_line;
        end
    end

    assign o_line = r_line;

endmodule

FILE: hdl/slcp_accounting.sv
// Line completion: event decision, sequence tracking, counters, mode and the
// period registers. Depends on slcp_pkg.
module slcp_accounting (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_byte,
    input  slcp_pkg::t_line      i_line,
    input  slcp_pkg::t_cfg_write i_cfg,
    output slcp_pkg::t_result    o_result
);
    import slcp_pkg::*;

    logic [31:0] r_period_min, n_period_min;
    logic [31:0] r_period_max, n_period_max;
    logic        r_seq_valid, n_seq_valid;
    logic [31:0] r_next_exp, n_next_exp;
    logic [7:0]  r_mode, n_mode;
    logic [31:0] r_pings, n_pings;
    logic [31:0] r_bads, n_bads;
    logic [31:0] r_gaps, n_gaps;
    logic [31:0] r_dups, n_dups;

    t_event      ev;
    logic [31:0] value;
    logic [31:0] v;
    logic [31:0] seq_inc;

    assign v       = i_line.accum;
    assign seq_inc = v + 32'd1;

    // Event of a finished line and the state it changes.
    always_comb begin
        n_period_min = r_period_min;
        n_period_max = r_period_max;
        n_seq_valid  = r_seq_valid;
        n_next_exp   = r_next_exp;
        n_mode       = r_mode;
        n_pings      = r_pings;
        n_bads       = r_bads;
        n_gaps       = r_gaps;
        n_dups       = r_dups;
        ev           = EV_NONE;
        value        = 32'd0;

        if (i_cfg.en) begin
            case (i_cfg.index)
                CFG_PERIOD_MIN: n_period_min = i_cfg.data;
                CFG_PERIOD_MAX: n_period_max = i_cfg.data;
                default:        n_period_min = r_period_min;
            endcase
        end

        if (i_step && (i_byte == CH_NL)) begin
            if (i_line.too_long) begin
                ev = EV_BAD;
            end else if (i_line.phase == PH_LEAD) begin
                ev = EV_NONE;
            end else if ((i_line.phase == PH_BAD) || (i_line.phase == PH_PRE_NUM)) begin
                ev = EV_BAD;
            end else if (i_line.tag == TAG_Z) begin
                ev          = EV_RESET;
                n_pings     = 32'd0;
                n_bads      = 32'd0;
                n_gaps      = 32'd0;
                n_dups      = 32'd0;
                n_seq_valid = 1'b0;
                n_next_exp  = 32'd0;
            end else if (!i_line.digit_seen || i_line.overflow) begin
                ev = EV_BAD;
            end else begin
                case (i_line.tag)
                    TAG_P: begin
                        ev      = EV_PING;
                        value   = v;
                        n_pings = r_pings + 32'd1;
                        if (!r_seq_valid || (v == r_next_exp)) begin
                            n_seq_valid = 1'b1;
                            n_next_exp  = seq_inc;
                        end else if (v > r_next_exp) begin
                            n_gaps     = r_gaps + (v - r_next_exp);
                            n_next_exp = seq_inc;
                        end else begin
                            n_dups = r_dups + 32'd1;
                        end
                    end
                    TAG_S: begin
                        if (v > MODE_LIMIT) begin
                            ev = EV_BAD;
                        end else begin
                            ev     = EV_MODE;
                            value  = v;
                            n_mode = v[7:0];
                        end
                    end
                    TAG_B: begin
                        ev    = EV_BAUD;
                        value = v;
                    end
                    TAG_N: begin
                        if ((v < r_period_min) || (v > r_period_max)) begin
                            ev = EV_BAD;
                        end else begin
                            ev    = EV_PERIOD;
                            value = v;
                        end
                    end
                    default: begin
                        ev = EV_BAD;
                    end
                endcase
            end
            if (ev == EV_BAD) begin
                n_bads = r_bads + 32'd1;
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_min <= PERIOD_MIN_RESET;
            r_period_max <= PERIOD_MAX_RESET;
            r_seq_valid  <= 1'b0;
            r_next_exp   <= 32'd0;
            r_mode       <= MODE_RESET;
            r_pings      <= 32'd0;
            r_bads       <= 32'd0;
            r_gaps       <= 32'd0;
            r_dups       <= 32'd0;
        end else begin
            r_period_min <= n_period_min;
            r_period_max <= n_period_max;
            r_seq_valid  <= n_seq_valid;
            r_next_exp   <= n_next_exp;
            r_mode       <= n_mode;
            r_pings      <= n_pings;
            r_bads       <= n_bads;
            r_gaps       <= n_gaps;
            r_dups       <= n_dups;
        end
    end

    // Result as seen after this byte.
    always_comb begin
        o_result.event_code  = ev;
        o_result.event_value = value;
        o_result.mode_now    = n_mode;
        o_result.ping_count  = n_pings;
        o_result.bad_count   = n_bads;
        o_result.gap_count   = n_gaps;
        o_result.dup_count   = n_dups;
    end

endmodule

FILE: hdl/seq_line_command_parser.sv
// Path: an accepted byte is held in the input register, then its result is registered in the result register.
// Throughput: one byte per cycle while results are taken; with both registers full, input ready follows result ready.
// Stall: with both registers full and the result not taken, the byte input holds off.
// Reset: synchronous, active low; counters and sequence cleared, mode set to MODE_MAX,
// period bounds set to 10 and 1000; no clearing pass, the block is ready right after reset.
// Top level; depends on slcp_pkg, slcp_if, slcp_lexer, slcp_accounting and the assertion header.
module seq_line_command_parser (
    input  logic         i_clk,
    input  logic         i_rst_n,
    slcp_rx_if.sink      i_rx,
    slcp_cfg_if.sink     i_cfg,
    slcp_res_if.source   o_res
);
    import slcp_pkg::*;

    `include "seq_line_command_parser_assert.svh"

    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_out_valid;
    t_result    r_result;

    logic       advance;
    logic       in_ready;
    t_line      line;
    t_cfg_write cfg;
    t_result    result;

    // A request moves from the input register into the result register when
    // the result register is empty or being emptied.
    assign advance  = r_in_valid && (!r_out_valid || o_res.ready);
    assign in_ready = !r_in_valid || advance;

    assign i_rx.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

    // Configuration write request.
    always_comb begin
        cfg.en    = i_cfg.valid;
        cfg.index = i_cfg.index;
        cfg.data  = i_cfg.data;
    end

    slcp_lexer u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_byte  (r_byte),
        .o_line  (line)
    );

    slcp_accounting u_accounting (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_byte   (r_byte),
        .i_line   (line),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_rx.valid;
        end
        if (in_ready && i_rx.valid) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_result <= result;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.event_code  = r_result.event_code;
    assign o_res.event_value = r_result.event_value;
    assign o_res.mode_now    = r_result.mode_now;
    assign o_res.ping_count  = r_result.ping_count;
    assign o_res.bad_count   = r_result.bad_count;
    assign o_res.gap_count   = r_result.gap_count;
    assign o_res.dup_count   = r_result.dup_count;

    // A full pipeline with the result held must not take another byte.
    `SLCP_ASSERT_IMP(a_stall_blocks_input, i_clk, i_rst_n, r_in_valid && r_out_valid && !o_res.ready, !i_rx.ready, "input accepted while pipeline is blocked")
    // Only number-carrying events report a value.
    `SLCP_ASSERT_IMP(a_value_only_for_numbers, i_clk, i_rst_n, r_out_valid && (r_result.event_value != 32'd0), (r_result.event_code == EV_PING) || (r_result.event_code == EV_MODE) || (r_result.event_code == EV_BAUD) || (r_result.event_code == EV_PERIOD), "value reported for an event without a number")
    // A clear line leaves all counters at zero.
    `SLCP_ASSERT_IMP(a_reset_clears_counters, i_clk, i_rst_n, r_out_valid && (r_result.event_code == EV_RESET), (r_result.ping_count == 32'd0) && (r_result.bad_count == 32'd0) && (r_result.gap_count == 32'd0) && (r_result.dup_count == 32'd0), "counters not cleared by a clear line")
    // The mode never leaves its allowed range.
    `SLCP_ASSERT_IMP(a_mode_in_range, i_clk, i_rst_n, r_out_valid, r_result.mode_now <= MODE_RESET, "mode above its maximum")
    // A byte taken at the input is presented in the input register next cycle.
    `SLCP_ASSERT_NXT(a_byte_enters, i_clk, i_rst_n, i_rx.valid && i_rx.ready, r_in_valid, "accepted byte lost at the input register")

endmodule
